[src/gray8_frame_rotator_core_assert.svh]
`ifndef GRAY8_FRAME_ROTATOR_CORE_ASSERT_SVH
`define GRAY8_FRAME_ROTATOR_CORE_ASSERT_SVH

// clocked check, off while reset is high
`define GRFR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("grfr check failed");

// clocked check that also covers the reset cycles
`define GRFR_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("grfr reset check failed");

`endif

[src/grfr_pkg.sv]
`timescale 1ns / 1ps

package grfr_pkg;

   localparam int MAX_DIM    = 512;
   localparam int COORD_W    = $clog2(MAX_DIM);
   localparam int DIM_W      = $clog2(MAX_DIM + 1);
   localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM);
   localparam int MEM_ADDR_W = ADDR_W + 1;
   localparam int MEM_DEPTH  = 2 ** MEM_ADDR_W;

   localparam int PIXEL_W     = 8;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int TURN_W      = 2;

   localparam int FRAME_DIM_RESET = 512;

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   // width of the checker's count of accepted but unanswered pixels
   localparam int PENDING_W = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_QUARTER_TURNS = 2'd2
   } csr_index_type;

   typedef enum logic [TURN_W-1:0] {
      TURN_0   = 2'd0,
      TURN_90  = 2'd1,
      TURN_180 = 2'd2,
      TURN_270 = 2'd3
   } turn_type;

   // one pixel transaction as handed from the front to the back
   typedef struct packed {
      logic [ADDR_W-1:0]  rd_base;
      logic [COORD_W-1:0] rd_offset;
      logic [ADDR_W-1:0]  wr_base;
      logic [COORD_W-1:0] wr_offset;
      logic               fill_bank;
      logic [PIXEL_W-1:0] pixel;
      logic               primed;
      logic               frame_end;
   } cmd_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] value);
      logic [DIM_W-1:0] result;
      if (value == '0) begin
         result = DIM_W'(1);
      end else if (int'(value) > MAX_DIM) begin
         result = DIM_W'(MAX_DIM);
      end else begin
         result = DIM_W'(value);
      end
      return result;
   endfunction

endpackage

[src/gray8_frame_rotator_core.sv]
`timescale 1ns / 1ps
// Rotates 8-bit grayscale frames clockwise by 0, 90, 180 or 270 degrees.
// Input queue side: drive req_pixel_in with req_push; a pixel is taken on an
// edge where req_push is high and req_full is low. Pixels come in raster order.
// Result queue side: while rsp_empty is low the oldest result sits on
// rsp_pixel_out, rsp_out_valid and rsp_frame_end; rsp_pop takes it.
// Each pixel gives exactly one result: the rotated previous frame in output
// raster order, zero with out_valid low during the first frame.
// Control writes (csr_index 0 width, 1 height, 2 quarter turns) use csr_valid/
// csr_ready, always high; the user must write only while no transaction is in
// flight, which the block does not enforce.
// Throughput: one pixel per clock while req_full is low, set by the single write
// and single read port of the frame memory, one on each bank per cycle.
// If rsp_pop stays low, results collect in a four-entry queue and the
// internal four-entry transaction queue, then req_full rises; nothing is lost.
// Reset (synchronous, active high) clears the counters, bank select, the
// primed flag and both queues; memory contents are left as they are.

module gray8_frame_rotator_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [grfr_pkg::PIXEL_W-1:0]     req_pixel_in,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [grfr_pkg::PIXEL_W-1:0]     rsp_pixel_out,
   output logic                             rsp_out_valid,
   output logic                             rsp_frame_end,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [grfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [grfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import grfr_pkg::*;

   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;
   cmd_type cmd_in;
   cmd_type cmd_out;

   grfr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_pixel_in (req_pixel_in),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd_push     (cmd_push),
      .cmd_full     (cmd_full),
      .cmd_data     (cmd_in)
   );

   grfr_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .full      (cmd_full),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (cmd_out)
   );

   grfr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (cmd_empty),
      .cmd_pop       (cmd_pop),
      .cmd_data      (cmd_out),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_valid (rsp_out_valid),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

[src/grfr_front.sv]
`timescale 1ns / 1ps

module grfr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [grfr_pkg::PIXEL_W-1:0]     req_pixel_in,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [grfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [grfr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                             cmd_push,
   input  logic                             cmd_full,
   output grfr_pkg::cmd_type                cmd_data
);
   import grfr_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] rd_a;
      logic [DIM_W-1:0]   rd_b;
      logic [COORD_W-1:0] rd_offset;
      logic [COORD_W-1:0] wr_a;
      logic [DIM_W-1:0]   wr_b;
      logic [COORD_W-1:0] wr_offset;
      logic               fill_bank;
      logic [PIXEL_W-1:0] pixel;
      logic               primed;
      logic               frame_end;
   } stage_type;

   logic [DIM_W-1:0]   frame_width_ff, frame_width_in;
   logic [DIM_W-1:0]   frame_height_ff, frame_height_in;
   turn_type           quarter_turns_ff, quarter_turns_in;
   logic [COORD_W-1:0] column_count_ff, column_count_in;
   logic [COORD_W-1:0] row_count_ff, row_count_in;
   logic               fill_bank_ff, fill_bank_in;
   logic               primed_ff, primed_in;
   logic               stage_valid_ff, stage_valid_in;
   stage_type          stage_ff, stage_in;

   logic               accept;
   logic               csr_write;
   logic [DIM_W-1:0]   width_last;
   logic [DIM_W-1:0]   height_last;
   logic [COORD_W-1:0] x;
   logic [COORD_W-1:0] y;
   logic [COORD_W-1:0] x_mirror;
   logic [COORD_W-1:0] y_mirror;
   logic               last_col;
   logic               last_row;
   logic               last_pix;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_full  = stage_valid_ff && cmd_full;
   assign accept    = req_push && !req_full;
   assign cmd_push  = stage_valid_ff && !cmd_full;

   // position in the frame, clamped to the current size
   always_comb begin
      width_last  = frame_width_ff - DIM_W'(1);
      height_last = frame_height_ff - DIM_W'(1);
      x = (DIM_W'(column_count_ff) < frame_width_ff) ? column_count_ff
                                                      : COORD_W'(width_last);
      y = (DIM_W'(row_count_ff) < frame_height_ff) ? row_count_ff
                                                    : COORD_W'(height_last);
      x_mirror = COORD_W'(width_last - DIM_W'(x));
      y_mirror = COORD_W'(height_last - DIM_W'(y));
      last_col = (DIM_W'(x) == width_last);
      last_row = (DIM_W'(y) == height_last);
      last_pix = last_col && last_row;
   end

   always_comb begin
      frame_width_in   = frame_width_ff;
      frame_height_in  = frame_height_ff;
      quarter_turns_in = quarter_turns_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_in = clamp_dim(csr_wdata);
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_in = clamp_dim(csr_wdata);
            end
            CSR_QUARTER_TURNS: begin
               quarter_turns_in = turn_type'(csr_wdata[TURN_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      fill_bank_in    = fill_bank_ff;
      primed_in       = primed_ff;
      if (accept) begin
         priority if (last_pix) begin
            column_count_in = '0;
            row_count_in    = '0;
            fill_bank_in    = !fill_bank_ff;
            primed_in       = 1'b1;
         end else if (last_col) begin
            column_count_in = '0;
            row_count_in    = y + COORD_W'(1);
         end else begin
            column_count_in = x + COORD_W'(1);
            row_count_in    = y;
         end
      end
   end

   // operands for the raster read address and the rotated write address
   always_comb begin
      stage_in           = stage_ff;
      stage_valid_in     = stage_valid_ff;
      if (accept) begin
         stage_valid_in     = 1'b1;
         stage_in.rd_a      = y;
         stage_in.rd_b      = frame_width_ff;
         stage_in.rd_offset = x;
         stage_in.fill_bank = fill_bank_ff;
         stage_in.pixel     = req_pixel_in;
         stage_in.primed    = primed_ff;
         stage_in.frame_end = last_pix;
         unique case (quarter_turns_ff)
            TURN_90: begin
               stage_in.wr_a      = x;
               stage_in.wr_b      = frame_height_ff;
               stage_in.wr_offset = y_mirror;
            end
            TURN_180: begin
               stage_in.wr_a      = y_mirror;
               stage_in.wr_b      = frame_width_ff;
               stage_in.wr_offset = x_mirror;
            end
            TURN_270: begin
               stage_in.wr_a      = x_mirror;
               stage_in.wr_b      = frame_height_ff;
               stage_in.wr_offset = y;
            end
            TURN_0: begin
               stage_in.wr_a      = y;
               stage_in.wr_b      = frame_width_ff;
               stage_in.wr_offset = x;
            end
         endcase
      end else if (cmd_push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      cmd_data.rd_base   = ADDR_W'(stage_ff.rd_a) * ADDR_W'(stage_ff.rd_b);
      cmd_data.rd_offset = stage_ff.rd_offset;
      cmd_data.wr_base   = ADDR_W'(stage_ff.wr_a) * ADDR_W'(stage_ff.wr_b);
      cmd_data.wr_offset = stage_ff.wr_offset;
      cmd_data.fill_bank = stage_ff.fill_bank;
      cmd_data.pixel     = stage_ff.pixel;
      cmd_data.primed    = stage_ff.primed;
      cmd_data.frame_end = stage_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= clamp_dim(CSR_DATA_W'(FRAME_DIM_RESET));
         frame_height_ff  <= clamp_dim(CSR_DATA_W'(FRAME_DIM_RESET));
         quarter_turns_ff <= TURN_0;
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         fill_bank_ff     <= 1'b0;
         primed_ff        <= 1'b0;
         stage_valid_ff   <= 1'b0;
      end else begin
         frame_width_ff   <= frame_width_in;
         frame_height_ff  <= frame_height_in;
         quarter_turns_ff <= quarter_turns_in;
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
         fill_bank_ff     <= fill_bank_in;
         primed_ff        <= primed_in;
         stage_valid_ff   <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

[src/grfr_cmd_queue.sv]
`timescale 1ns / 1ps

module grfr_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  grfr_pkg::cmd_type push_data,
   input  logic              pop,
   output logic              empty,
   output grfr_pkg::cmd_type pop_data
);
   import grfr_pkg::*;

   cmd_type                entries_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full     = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMDQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMDQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CMDQ_CNT_W'(do_push) - CMDQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/grfr_back.sv]
`timescale 1ns / 1ps

module grfr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_empty,
   output logic                         cmd_pop,
   input  grfr_pkg::cmd_type            cmd_data,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [grfr_pkg::PIXEL_W-1:0] rsp_pixel_out,
   output logic                         rsp_out_valid,
   output logic                         rsp_frame_end
);
   import grfr_pkg::*;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               out_valid;
      logic               frame_end;
   } rsp_entry_type;

   logic [PIXEL_W-1:0]    frame_banks [MEM_DEPTH];

   logic                  addr_valid_ff;
   logic [MEM_ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [MEM_ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [PIXEL_W-1:0]    wr_pixel_ff;
   logic                  addr_primed_ff;
   logic                  addr_last_ff;

   logic                  data_valid_ff;
   logic [PIXEL_W-1:0]    rd_data_ff;
   logic                  data_primed_ff;
   logic                  data_last_ff;

   rsp_entry_type         rspq_ff [RSPQ_DEPTH];
   rsp_entry_type         rspq_in;
   logic [RSPQ_PTR_W-1:0] rspq_wr_ptr_ff;
   logic [RSPQ_PTR_W-1:0] rspq_rd_ptr_ff;
   logic [RSPQ_CNT_W-1:0] rspq_count_ff;
   logic [RSPQ_CNT_W:0]   committed;
   logic                  rsp_take;

   // results in the memory pipeline plus results waiting must fit the queue
   assign committed = (RSPQ_CNT_W + 1)'(addr_valid_ff) + (RSPQ_CNT_W + 1)'(data_valid_ff)
                      + (RSPQ_CNT_W + 1)'(rspq_count_ff);
   assign cmd_pop   = !cmd_empty && (committed < (RSPQ_CNT_W + 1)'(RSPQ_DEPTH));

   assign rd_addr_in = {!cmd_data.fill_bank, cmd_data.rd_base + ADDR_W'(cmd_data.rd_offset)};
   assign wr_addr_in = {cmd_data.fill_bank, cmd_data.wr_base + ADDR_W'(cmd_data.wr_offset)};

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_valid_ff <= 1'b0;
         data_valid_ff <= 1'b0;
      end else begin
         addr_valid_ff <= cmd_pop;
         data_valid_ff <= addr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rd_addr_ff     <= rd_addr_in;
         wr_addr_ff     <= wr_addr_in;
         wr_pixel_ff    <= cmd_data.pixel;
         addr_primed_ff <= cmd_data.primed;
         addr_last_ff   <= cmd_data.frame_end;
      end
      data_primed_ff <= addr_primed_ff;
      data_last_ff   <= addr_last_ff;
   end

   // read and write hit opposite banks, so they never collide
   always_ff @(posedge clock) begin
      if (addr_valid_ff) begin
         frame_banks[wr_addr_ff] <= wr_pixel_ff;
         rd_data_ff              <= frame_banks[rd_addr_ff];
      end
   end

   assign rsp_take  = rsp_pop && !rsp_empty;
   assign rsp_empty = (rspq_count_ff == '0);

   always_comb begin
      rspq_in.pixel     = data_primed_ff ? rd_data_ff : '0;
      rspq_in.out_valid = data_primed_ff;
      rspq_in.frame_end = data_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rspq_wr_ptr_ff <= '0;
         rspq_rd_ptr_ff <= '0;
         rspq_count_ff  <= '0;
      end else begin
         if (data_valid_ff) begin
            rspq_wr_ptr_ff <= rspq_wr_ptr_ff + RSPQ_PTR_W'(1);
         end
         if (rsp_take) begin
            rspq_rd_ptr_ff <= rspq_rd_ptr_ff + RSPQ_PTR_W'(1);
         end
         rspq_count_ff <= rspq_count_ff + RSPQ_CNT_W'(data_valid_ff) - RSPQ_CNT_W'(rsp_take);
      end
   end

   always_ff @(posedge clock) begin
      if (data_valid_ff) begin
         rspq_ff[rspq_wr_ptr_ff] <= rspq_in;
      end
   end

   assign rsp_pixel_out = rspq_ff[rspq_rd_ptr_ff].pixel;
   assign rsp_out_valid = rspq_ff[rspq_rd_ptr_ff].out_valid;
   assign rsp_frame_end = rspq_ff[rspq_rd_ptr_ff].frame_end;

endmodule

[src/grfr_checker.sv]
`timescale 1ns / 1ps
`include "gray8_frame_rotator_core_assert.svh"

module grfr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_push,
   input logic                         req_full,
   input logic                         rsp_empty,
   input logic                         rsp_pop,
   input logic [grfr_pkg::PIXEL_W-1:0] rsp_pixel_out,
   input logic                         rsp_out_valid,
   input logic                         rsp_frame_end
);
   import grfr_pkg::*;

   logic [PENDING_W-1:0] pending_ff, pending_in;
   logic                 seen_valid_ff, seen_valid_in;
   logic                 in_take;
   logic                 out_take;

   assign in_take  = req_push && !req_full;
   assign out_take = rsp_pop && !rsp_empty;

   always_comb begin
      pending_in    = pending_ff + PENDING_W'(in_take) - PENDING_W'(out_take);
      seen_valid_in = seen_valid_ff || (out_take && rsp_out_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         seen_valid_ff <= 1'b0;
      end else begin
         pending_ff    <= pending_in;
         seen_valid_ff <= seen_valid_in;
      end
   end

   `GRFR_ASSERT_ALWAYS(a_reset_clears_results, reset |=> rsp_empty)
   `GRFR_ASSERT(a_no_result_without_pixel, (pending_ff == '0) |-> rsp_empty)
   `GRFR_ASSERT(a_first_frame_zero, (!rsp_empty && !rsp_out_valid) |-> (rsp_pixel_out == '0))
   `GRFR_ASSERT(a_valid_stays_high, (!rsp_empty && seen_valid_ff) |-> rsp_out_valid)
   `GRFR_ASSERT(a_result_holds, $past(!reset) && $past(!rsp_empty) && $past(!rsp_pop) |-> !rsp_empty && $stable(rsp_pixel_out) && $stable(rsp_frame_end))

endmodule

bind gray8_frame_rotator_core grfr_checker u_grfr_checker (.*);
